// File: design/ssq_pkg.sv
// Shared types and constants for the sorted set / queue / stack array.
// Used by ssq_ctrl, ssq_dpath and sorted_set_queue_stack_array.
package ssq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int CNT_OUT_W    = 7;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_DEQUEUE = 3'd3,
    CMD_POP     = 3'd4,
    CMD_PEEK    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]              command;
    logic                    modify_request;
    logic signed [KEY_W-1:0] item;
    logic signed [KEY_W-1:0] new_item;
  } in_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [KEY_W-1:0] data;
    logic [CNT_OUT_W-1:0]    count;
  } out_t;

  typedef struct packed {
    logic latch;
    logic compare;
    logic execute;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// File: design/sorted_set_queue_stack_array.sv
// Sorted set / queue / stack array: keeps up to CAPACITY signed 32-bit keys
// packed from slot 0 in a row of cells with parallel compare and shift. Every
// command runs in order from input beat to result beat: latch the beat, all
// cells compare against the key, then shift or update the cells and load the
// result register, waiting while an earlier result is held. A new beat is taken
// as soon as the previous command has loaded its result, even while it waits.
// Depends on ssq_pkg, ssq_ctrl and ssq_dpath.
module sorted_set_queue_stack_array #(
  parameter int CAPACITY = ssq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ssq_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  ssq_pkg::ctl_t ctl;
  ssq_pkg::sts_t sts;

  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ssq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/ssq_ctrl.sv
// Controller state machine: latch, compare, execute sequence per beat.
// Depends on ssq_pkg.
module ssq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssq_pkg::sts_t sts,
  output ssq_pkg::ctl_t ctl
);

  ssq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ssq_pkg::S_CMP;
      end
      ssq_pkg::S_CMP: begin
        state_nxt = ssq_pkg::S_EXEC;
      end
      ssq_pkg::S_EXEC: begin
        if (!sts.out_busy) state_nxt = ssq_pkg::S_IDLE;
      end
      default: state_nxt = ssq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl.latch   = 1'b0;
    ctl.compare = 1'b0;
    ctl.execute = 1'b0;
    unique case (state_r)
      ssq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
      end
      ssq_pkg::S_CMP: begin
        ctl.compare = 1'b1;
      end
      ssq_pkg::S_EXEC: begin
        ctl.execute = !sts.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: design/ssq_dpath.sv
// Datapath: row of key cells with per-cell compare and shift, count, mode flags
// and the result register. Depends on ssq_pkg.
module ssq_dpath #(
  parameter int CAPACITY = ssq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ssq_pkg::ctl_t ctl,
  output ssq_pkg::sts_t sts,
  input  ssq_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output ssq_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = ssq_pkg::KEY_W;

  logic [KW-1:0]       ent_r [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  logic                sorted_r, sorted_nxt;
  logic                evict_r;
  ssq_pkg::in_t        req_r;
  logic [CAPACITY-1:0] eq_r, lt_r;
  ssq_pkg::out_t       out_r;
  logic                out_valid_r;

  logic [CAPACITY-1:0] valid, ge_ins, ins_first, mfound, sh_mask, mod_oh, rear_oh;
  logic                full, empty, found, ins_pos_ok, use_sort;
  logic                do_ins, do_shift, do_mod;
  logic [2:0]          status;
  logic [KW-1:0]       data, rear_data;

  function automatic logic [CAPACITY-1:0] pfx_or(input logic [CAPACITY-1:0] x);
    logic [CAPACITY-1:0] y;
    y = x;
    for (int s = 1; s < CAPACITY; s = s * 2) y = y | (y << s);
    return y;
  endfunction

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) valid[i] = (CW'(i) < count_r);
    full       = (count_r == CW'(CAPACITY));
    empty      = (count_r == '0);
    use_sort   = sorted_r && !req_r.modify_request && (req_r.command == ssq_pkg::CMD_INSERT);
    ge_ins     = use_sort ? (pfx_or(lt_r & valid) | ~valid) : ~valid;
    ins_first  = ge_ins & ~(ge_ins << 1);
    ins_pos_ok = |ge_ins;
    mfound     = eq_r & valid;
    found      = |mfound;
    mod_oh     = pfx_or(mfound) & ~(pfx_or(mfound) << 1);
    rear_oh    = valid & ~(valid >> 1);
    rear_data  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rear_oh[i]) rear_data = rear_data | ent_r[i];
    end
  end

  always_comb begin
    status     = ssq_pkg::ST_OK;
    data       = '0;
    count_nxt  = count_r;
    sorted_nxt = sorted_r;
    do_ins     = 1'b0;
    do_shift   = 1'b0;
    do_mod     = 1'b0;
    sh_mask    = pfx_or(mfound);
    if (req_r.modify_request) begin
      if (found) begin
        do_mod     = 1'b1;
        sorted_nxt = 1'b0;
      end else begin
        status = ssq_pkg::ST_NOTFOUND;
      end
    end else begin
      case (req_r.command)
        ssq_pkg::CMD_INSERT: begin
          if (found) begin
            status = ssq_pkg::ST_DUP;
          end else if (full) begin
            if (sorted_r && evict_r && ins_pos_ok) begin
              do_ins = 1'b1;
            end else begin
              status = ssq_pkg::ST_FULL;
            end
          end else begin
            do_ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ssq_pkg::CMD_APPEND: begin
          sorted_nxt = 1'b0;
          if (full) begin
            status = ssq_pkg::ST_FULL;
          end else begin
            do_ins    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        ssq_pkg::CMD_REMOVE: begin
          if (empty) begin
            status = ssq_pkg::ST_EMPTY;
          end else if (found) begin
            do_shift  = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            status = ssq_pkg::ST_NOTFOUND;
          end
        end
        ssq_pkg::CMD_DEQUEUE: begin
          if (empty) begin
            status = ssq_pkg::ST_EMPTY;
          end else begin
            data      = ent_r[0];
            do_shift  = 1'b1;
            sh_mask   = '1;
            count_nxt = count_r - 1'b1;
          end
        end
        ssq_pkg::CMD_POP: begin
          if (empty) begin
            status = ssq_pkg::ST_EMPTY;
          end else begin
            data      = rear_data;
            count_nxt = count_r - 1'b1;
          end
        end
        ssq_pkg::CMD_PEEK: begin
          if (empty) begin
            status = ssq_pkg::ST_EMPTY;
          end else begin
            data = rear_data;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KW-1:0] up_val, dn_val;
    if (g == 0) begin : g_first
      assign up_val = req_r.item;
    end else begin : g_mid
      assign up_val = ent_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_val = ent_r[g];
    end else begin : g_body
      assign dn_val = ent_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.compare) begin
        eq_r[g] <= (ent_r[g] == req_r.item);
        lt_r[g] <= ($signed(req_r.item) < $signed(ent_r[g]));
      end
      if (ctl.execute) begin
        if (do_ins && ge_ins[g]) begin
          ent_r[g] <= ins_first[g] ? req_r.item : up_val;
        end else if (do_shift && sh_mask[g]) begin
          ent_r[g] <= dn_val;
        end else if (do_mod && mod_oh[g]) begin
          ent_r[g] <= req_r.new_item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) req_r <= in_data;
    if (ctl.execute) begin
      out_r.status <= status;
      out_r.data   <= data;
      out_r.count  <= ssq_pkg::CNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sorted_r    <= 1'b1;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) evict_r <= cfg_wdata;
      if (ctl.execute) begin
        count_r     <= count_nxt;
        sorted_r    <= sorted_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
